>>> hw/rtl/thv_pkg.sv
// thv_pkg: shared types, constants and field layout for the tar header validator
// no dependencies
`timescale 1ns / 1ps
package thv_pkg;

  localparam int HeaderBytes = 512;
  localparam int PosW = 9;

  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_END      = 3'd1;
  localparam logic [2:0] ST_FIELD    = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_TYPE     = 3'd4;
  localparam logic [2:0] ST_INCONS   = 3'd5;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_TAIL  = 2'd2;

  localparam logic [1:0] FMT_ANY = 2'd0;
  localparam logic [1:0] FMT_PAX = 2'd1;
  localparam logic [1:0] FMT_GNU = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] FLD_MODE = 4'd0;
  localparam logic [3:0] FLD_UID  = 4'd1;
  localparam logic [3:0] FLD_GID  = 4'd2;
  localparam logic [3:0] FLD_SIZE = 4'd3;
  localparam logic [3:0] FLD_TIME = 4'd4;
  localparam logic [3:0] FLD_CHK  = 4'd5;
  localparam logic [3:0] FLD_DMAJ = 4'd6;
  localparam logic [3:0] FLD_DMIN = 4'd7;
  localparam logic [3:0] FLD_NONE = 4'd8;

  typedef struct packed {
    logic [8:0] start;
    logic [8:0] last;
  } fld_range_t;

  function automatic fld_range_t fld_range(input logic [2:0] k);
    fld_range_t r;
    r = '{start: 9'd0, last: 9'd0};
    case (k)
      3'd0: r = '{start: 9'd100, last: 9'd107};
      3'd1: r = '{start: 9'd108, last: 9'd115};
      3'd2: r = '{start: 9'd116, last: 9'd123};
      3'd3: r = '{start: 9'd124, last: 9'd135};
      3'd4: r = '{start: 9'd136, last: 9'd147};
      3'd5: r = '{start: 9'd148, last: 9'd155};
      3'd6: r = '{start: 9'd329, last: 9'd336};
      default: r = '{start: 9'd337, last: 9'd344};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (i)
      3'd0: c = 8'h75;
      3'd1: c = 8'h73;
      3'd2: c = 8'h74;
      3'd3: c = 8'h61;
      3'd4: c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic [7:0]  b;
    logic [8:0]  pos;
    logic        last;
    logic        start;
    logic [3:0]  fld;
    logic        fld_last;
  } byte_info_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entry_type;
    logic [32:0] member_size;
    logic [8:0]  pad_bytes;
    logic [20:0] file_mode;
    logic [20:0] owner_id;
    logic [20:0] group_id;
    logic [32:0] mod_time;
    logic [20:0] device_major;
    logic [20:0] device_minor;
    logic        is_extended;
  } verdict_t;

endpackage

>>> hw/rtl/tar_header_validator.sv
// tar_header_validator: top level, one ustar header byte per word in, one verdict out
// depends on thv_pkg, thv_decode, thv_accum, thv_out_buf
`timescale 1ns / 1ps
// Usage:
//   s_axis carries header bytes, 512 words per header block, in order.
//   After the 512th byte one verdict word appears on m_axis.
//   cfg_valid/cfg_ready/cfg_data writes format_mode; write it only while idle.
// The verdict passes the byte tag stage, the accumulate stage and the output buffer.
// Throughput: 1 byte per cycle while s_axis_tready is high, set by the two register stages
//   (byte tag stage and the accumulate stage) that each take one byte per clock.
// A two-word output buffer holds verdicts; s_axis_tready falls only while both
//   words are full, so bytes keep flowing until then.
// Reset (rst, synchronous) clears the byte position, sums, flags, octal fields,
//   the output buffer and sets format_mode to any.
// When m_axis stalls, verdicts wait in the buffer, and input pauses only once
//   the buffer is full.
module tar_header_validator #(
  parameter int HEADER_BYTES = thv_pkg::HeaderBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // header_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], entry_type[10:3], member_size[43:11], pad_bytes[52:44],
  // file_mode[73:53], owner_id[94:74], group_id[115:95], mod_time[148:116],
  // device_major[169:149], device_minor[190:170], is_extended[191]
  output logic [191:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import thv_pkg::*;

  logic       in_take, dec_valid, res_valid, space_ok;
  logic [1:0] format_mode;
  byte_info_t dec_info;
  verdict_t   res, out_v;

  // headers are far apart, so only a full buffer can block the next verdict
  assign s_axis_tready = space_ok;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) format_mode <= FMT_ANY;
    else if (cfg_valid) format_mode <= cfg_data;
  end

  thv_decode #(.HEADER_BYTES(HEADER_BYTES)) u_dec (.clk, .rst, .in_take,
                                                   .in_byte(s_axis_tdata), .dec_valid,
                                                   .dec_info);
  thv_accum u_acc (.clk, .rst, .format_mode, .dec_valid, .dec_info, .res_valid, .res);
  thv_out_buf u_buf (.clk, .rst, .wr_valid(res_valid), .wr_data(res), .space_ok,
                     .rd_valid(m_axis_tvalid), .rd_data(out_v), .rd_ready(m_axis_tready));

  assign m_axis_tdata = {out_v.is_extended, out_v.device_minor, out_v.device_major,
                         out_v.mod_time, out_v.group_id, out_v.owner_id, out_v.file_mode,
                         out_v.pad_bytes, out_v.member_size, out_v.entry_type, out_v.status};
endmodule

>>> hw/rtl/thv_decode.sv
// thv_decode: registered byte stage, tags each byte with its position and field
// depends on thv_pkg
`timescale 1ns / 1ps
module thv_decode #(
  parameter int HEADER_BYTES = thv_pkg::HeaderBytes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_take,
  input  logic [7:0]          in_byte,
  output logic                dec_valid,
  output thv_pkg::byte_info_t dec_info
);
  import thv_pkg::*;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic [3:0]      fld_next;
  logic            start_next;
  logic            flast_next;
  fld_range_t      r;

  always_comb begin
    fld_next   = FLD_NONE;
    start_next = 1'b0;
    flast_next = 1'b0;
    r          = '{start: 9'd0, last: 9'd0};
    for (int k = 0; k < 8; k++) begin
      r = fld_range(3'(k));
      if (pos >= r.start && pos <= r.last) begin
        fld_next   = 4'(k);
        start_next = (pos == r.start);
        flast_next = (pos == r.last);
      end
    end
    pos_next = (pos == PosW'(HEADER_BYTES - 1)) ? '0 : pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_take;
      if (in_take) pos <= pos_next;
    end
    if (in_take) begin
      dec_info.b        <= in_byte;
      dec_info.pos      <= pos;
      dec_info.last     <= (pos == PosW'(HEADER_BYTES - 1));
      dec_info.start    <= start_next;
      dec_info.fld      <= fld_next;
      dec_info.fld_last <= flast_next;
    end
  end
endmodule

>>> hw/rtl/thv_accum.sv
// thv_accum: sums, flags and octal field parsers, builds the verdict at the last byte
// depends on thv_pkg
`timescale 1ns / 1ps
module thv_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          format_mode,
  input  logic                dec_valid,
  input  thv_pkg::byte_info_t dec_info,
  output logic                res_valid,
  output thv_pkg::verdict_t   res
);
  import thv_pkg::*;

  logic [16:0] usum;
  logic [17:0] ssum;
  logic        all_zero;
  logic [1:0]  phase;
  logic        ferr;
  logic [32:0] acc [8];
  logic [7:0]  tchar;
  logic        magic_bad, uname_nul, gname_nul, link_set;

  logic [16:0] usum_next;
  logic [17:0] ssum_next;
  logic        all_zero_next, ferr_next, magic_bad_next, uname_next, gname_next, link_next;
  logic [1:0]  phase_next;
  logic [32:0] acc_val, acc_next;
  logic [7:0]  tchar_next, v, b, t;
  logic [8:0]  p;
  logic        dig, fill;
  logic [2:0]  k;
  logic        pax, gnu, type_ok, link, dev;
  logic [17:0] chk18;
  verdict_t    vd;

  always_comb begin
    b = dec_info.b;
    p = dec_info.pos;
    k = dec_info.fld[2:0];
    v = (p >= 9'd148 && p <= 9'd155) ? CH_SPACE : b;
    all_zero_next  = all_zero & (b == 8'h00);
    usum_next      = usum + {9'd0, v};
    ssum_next      = ssum + {{10{v[7]}}, v};
    magic_bad_next = magic_bad |
                     (p >= 9'd257 && p <= 9'd261 && b != magic_char(3'(p - 9'd257)));
    uname_next     = uname_nul | (p >= 9'd265 && p <= 9'd296 && b == 8'h00);
    gname_next     = gname_nul | (p >= 9'd297 && p <= 9'd328 && b == 8'h00);
    link_next      = link_set | (p == 9'd157 && b != 8'h00);
    tchar_next     = (p == 9'd156) ? b : tchar;

    dig        = (b >= CH_ZERO && b <= CH_SEVEN);
    fill       = (b == CH_SPACE || b == 8'h00);
    phase_next = dec_info.start ? PH_LEAD : phase;
    acc_val    = dec_info.start ? 33'd0 : acc[k];
    acc_next   = acc_val;
    ferr_next  = ferr;
    if (dec_info.fld != FLD_NONE) begin
      case (phase_next)
        PH_LEAD: begin
          if (b == CH_SPACE) begin
          end else if (dig && !dec_info.fld_last) begin
            phase_next = PH_DIGIT;
            acc_next   = {30'd0, b[2:0]};
          end else if (b == 8'h00) begin
            phase_next = PH_TAIL;
          end else begin
            ferr_next = 1'b1;
          end
        end
        PH_DIGIT: begin
          if (dig && !dec_info.fld_last) acc_next = {acc_val[29:0], b[2:0]};
          else if (fill) phase_next = PH_TAIL;
          else ferr_next = 1'b1;
        end
        default: begin
          if (!fill) ferr_next = 1'b1;
        end
      endcase
    end

    t       = (tchar_next == 8'h00) ? CH_ZERO : tchar_next;
    pax     = (format_mode == FMT_ANY || format_mode == FMT_PAX);
    gnu     = (format_mode == FMT_ANY || format_mode == FMT_GNU);
    type_ok = (t >= CH_ZERO && t <= CH_SEVEN) ||
              ((t == 8'h78 || t == 8'h67) && pax) || ((t == 8'h4b || t == 8'h4c) && gnu);
    link    = (t == 8'h31 || t == 8'h32);
    dev     = (t == 8'h33 || t == 8'h34);
    chk18   = {1'b0, acc[FLD_CHK[2:0]][16:0]};

    vd = '0;
    if (all_zero_next) vd.status = ST_END;
    else if (ferr_next || magic_bad_next || !uname_next || !gname_next) vd.status = ST_FIELD;
    else if ((acc[FLD_CHK[2:0]] != {16'd0, usum_next}) &&
             !(acc[FLD_CHK[2:0]][32:17] == 16'd0 && ssum_next == chk18))
      vd.status = ST_CHECKSUM;
    else if (!type_ok) vd.status = ST_TYPE;
    else if ((link_next && !link) || (link && acc[FLD_SIZE[2:0]] != 33'd0) ||
             ((acc[FLD_DMAJ[2:0]] | acc[FLD_DMIN[2:0]]) != 33'd0 && !dev))
      vd.status = ST_INCONS;
    else begin
      vd.status       = ST_VALID;
      vd.entry_type   = t;
      vd.member_size  = acc[FLD_SIZE[2:0]];
      vd.pad_bytes    = 9'(10'd512 - {1'b0, acc[FLD_SIZE[2:0]][8:0]});
      vd.file_mode    = acc[FLD_MODE[2:0]][20:0];
      vd.owner_id     = acc[FLD_UID[2:0]][20:0];
      vd.group_id     = acc[FLD_GID[2:0]][20:0];
      vd.mod_time     = acc[FLD_TIME[2:0]];
      vd.device_major = acc[FLD_DMAJ[2:0]][20:0];
      vd.device_minor = acc[FLD_DMIN[2:0]][20:0];
      vd.is_extended  = (t == 8'h78 || t == 8'h67 || t == 8'h4b || t == 8'h4c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= dec_valid && dec_info.last;
    end
    if (rst || (dec_valid && dec_info.last)) begin
      usum <= '0; ssum <= '0; all_zero <= 1'b1; phase <= PH_LEAD; ferr <= 1'b0;
      tchar <= '0; magic_bad <= 1'b0; uname_nul <= 1'b0; gname_nul <= 1'b0;
      link_set <= 1'b0;
      for (int i = 0; i < 8; i++) acc[i] <= '0;
    end else if (dec_valid) begin
      usum <= usum_next; ssum <= ssum_next; all_zero <= all_zero_next;
      ferr <= ferr_next; tchar <= tchar_next; magic_bad <= magic_bad_next;
      uname_nul <= uname_next; gname_nul <= gname_next; link_set <= link_next;
      if (dec_info.fld != FLD_NONE) begin
        phase  <= phase_next;
        acc[k] <= acc_next;
      end
    end
    if (dec_valid && dec_info.last) res <= vd;
  end
endmodule

>>> hw/rtl/thv_out_buf.sv
// thv_out_buf: two-entry output buffer holding verdict words for the master side
// depends on thv_pkg
`timescale 1ns / 1ps
module thv_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  input  thv_pkg::verdict_t wr_data,
  output logic              space_ok,
  output logic              rd_valid,
  output thv_pkg::verdict_t rd_data,
  input  logic              rd_ready
);
  import thv_pkg::*;

  verdict_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       rd_take;

  assign rd_take  = rd_valid && rd_ready;
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign space_ok = (cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr_valid) wp <= ~wp;
      if (rd_take) rp <= ~rp;
      cnt <= cnt + {1'b0, wr_valid} - {1'b0, rd_take};
    end
    if (wr_valid) mem[wp] <= wr_data;
  end
endmodule

>>> hw/rtl/thv_checker.sv
// thv_checker: port-level checks for tar_header_validator, bound to the top level
// depends on tar_header_validator ports only
`timescale 1ns / 1ps
module thv_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata
);
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5) else $error("bad status");
  a_nonvalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2:0] != 3'd0) |-> m_axis_tdata[191:3] == '0)
    else $error("fields on error verdict");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped");
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output after reset");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && !s_axis_tready) |-> m_axis_tvalid)
    else $error("input stalled with empty output");
endmodule

bind tar_header_validator thv_checker u_chk (.clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

>>> tb/tb_tar_header_validator.sv
// tb_tar_header_validator: stream testbench for the tar header validator, whole ustar
// header blocks built in place, verdicts predicted per byte and checked field by field
// depends on thv_pkg and tar_header_validator
`timescale 1ns / 1ps
module tb_tar_header_validator;
  import thv_pkg::*;

  localparam int WatchLimit = 20000;
  localparam logic [4:0] FL_MAGIC = 5'd1;
  localparam logic [4:0] FL_UNAME = 5'd2;
  localparam logic [4:0] FL_GNAME = 5'd4;
  localparam logic [4:0] FL_LINK  = 5'd8;

  localparam int MUT_NONE   = 0;
  localparam int MUT_FLIP   = 1;
  localparam int MUT_CHK    = 2;
  localparam int MUT_MAGIC  = 3;
  localparam int MUT_UNAME  = 4;
  localparam int MUT_GNAME  = 5;
  localparam int MUT_LASTD  = 6;
  localparam int MUT_BADCH  = 7;
  localparam int MUT_COUNT  = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  tar_header_validator DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial forever #4 clk = ~clk;

  // octal field layout: mode uid gid size mtime chksum devmajor devminor
  int unsigned oct_start [8] = '{100, 108, 116, 124, 136, 148, 329, 337};
  int unsigned oct_len   [8] = '{8, 8, 8, 12, 12, 8, 8, 8};
  int unsigned res_lo    [11] = '{0, 3, 11, 44, 53, 74, 95, 116, 149, 170, 191};
  int unsigned res_w     [11] = '{3, 8, 33, 9, 21, 21, 21, 33, 21, 21, 1};
  string res_name [11] = '{"status", "entry_type", "member_size", "pad_bytes", "file_mode",
    "owner_id", "group_id", "mod_time", "device_major", "device_minor", "is_extended"};

  // predictor state
  logic [1:0]  fmt;
  logic [8:0]  pos;
  logic [16:0] usum;
  int          ssum;
  bit          allz;
  logic [1:0]  phase;
  bit          ferr;
  logic [32:0] acc [8];
  logic [7:0]  tchar;
  logic [4:0]  flags;

  logic [191:0] verdict_q [$];
  logic [7:0] hdr [512];
  int errors = 0;
  int idle_tx = 0;
  int idle_rx = 0;
  int quiet = 0;

  task automatic clear_hdr_state();
    pos = '0; usum = '0; ssum = 0; allz = 1; phase = PH_LEAD; ferr = 0;
    foreach (acc[i]) acc[i] = '0;
    tchar = '0; flags = '0;
  endtask

  function automatic bit type_accepted(logic [7:0] t);
    bit pax, gnu;
    pax = (fmt == FMT_ANY || fmt == FMT_PAX);
    gnu = (fmt == FMT_ANY || fmt == FMT_GNU);
    if (t >= CH_ZERO && t <= CH_SEVEN) return 1;
    if ((t == "x" || t == "g") && pax) return 1;
    if ((t == "K" || t == "L") && gnu) return 1;
    return 0;
  endfunction

  task automatic octal_step(int k, logic [7:0] b);
    bit last, dig, fill;
    last = (pos == oct_start[k] + oct_len[k] - 1);
    dig = (b >= CH_ZERO && b <= CH_SEVEN);
    fill = (b == CH_SPACE || b == 8'h00);
    if (pos == oct_start[k]) begin
      phase = PH_LEAD;
      acc[k] = '0;
    end
    if (phase == PH_LEAD) begin
      if (b == CH_SPACE) return;
      if (dig && !last) begin
        phase = PH_DIGIT;
        acc[k] = 33'(b - CH_ZERO);
      end else if (b == 8'h00) begin
        phase = PH_TAIL;
      end else begin
        ferr = 1;
      end
    end else if (phase == PH_DIGIT) begin
      if (dig && !last) acc[k] = {acc[k][29:0], 3'(b - CH_ZERO)};
      else if (fill) phase = PH_TAIL;
      else ferr = 1;
    end else if (!fill) begin
      ferr = 1;
    end
  endtask

  function automatic logic [191:0] header_verdict();
    logic [7:0] t;
    logic [2:0] st;
    bit lnk, dev;
    t = (tchar == 8'h00) ? CH_ZERO : tchar;
    lnk = (t == "1" || t == "2");
    dev = (t == "3" || t == "4");
    if (allz) st = ST_END;
    else if (ferr || (flags & FL_MAGIC) != 0 || (flags & FL_UNAME) == 0 ||
             (flags & FL_GNAME) == 0) st = ST_FIELD;
    else if ({16'd0, usum} != acc[FLD_CHK[2:0]] &&
             longint'(ssum) != longint'(acc[FLD_CHK[2:0]]))
      st = ST_CHECKSUM;
    else if (!type_accepted(t)) st = ST_TYPE;
    else if (((flags & FL_LINK) != 0 && !lnk) || (lnk && acc[FLD_SIZE[2:0]] != 0) ||
             ((acc[FLD_DMAJ[2:0]] | acc[FLD_DMIN[2:0]]) != 0 && !dev)) st = ST_INCONS;
    else st = ST_VALID;
    if (st != ST_VALID) return {189'd0, st};
    return {1'(t == "x" || t == "g" || t == "K" || t == "L"),
            acc[FLD_DMIN[2:0]][20:0], acc[FLD_DMAJ[2:0]][20:0], acc[FLD_TIME[2:0]],
            acc[FLD_GID[2:0]][20:0], acc[FLD_UID[2:0]][20:0], acc[FLD_MODE[2:0]][20:0],
            9'(-acc[FLD_SIZE[2:0]][8:0]), acc[FLD_SIZE[2:0]], t, st};
  endfunction

  task automatic predict_byte(logic [7:0] b);
    logic [7:0] v;
    v = (pos >= 148 && pos <= 155) ? CH_SPACE : b;
    if (b != 0) allz = 0;
    usum = usum + 17'(v);
    ssum = ssum + int'($signed(v));
    if (pos >= 257 && pos <= 261 && b != magic_char(3'(pos - 257))) flags |= FL_MAGIC;
    if (pos >= 265 && pos <= 296 && b == 0) flags |= FL_UNAME;
    if (pos >= 297 && pos <= 328 && b == 0) flags |= FL_GNAME;
    if (pos == 156) tchar = b;
    if (pos == 157 && b != 0) flags |= FL_LINK;
    for (int k = 0; k < 8; k++)
      if (pos >= oct_start[k] && pos < oct_start[k] + oct_len[k]) octal_step(k, b);
    if (pos == 9'(HeaderBytes - 1)) begin
      verdict_q.push_back(header_verdict());
      clear_hdr_state();
    end else begin
      pos = pos + 9'd1;
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < idle_tx) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    predict_byte(b);
  endtask

  task automatic send_header();
    for (int i = 0; i < HeaderBytes; i++) send_byte(hdr[i]);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_format(logic [1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fmt = v;
  endtask

  task automatic put_octal(int k, logic [32:0] val, int lead, bit space_end);
    int nd;
    nd = oct_len[k] - 1 - lead;
    for (int i = 0; i < lead; i++) hdr[oct_start[k] + i] = CH_SPACE;
    for (int i = 0; i < nd; i++)
      hdr[oct_start[k] + lead + i] = CH_ZERO + 8'((val >> (3 * (nd - 1 - i))) & 7);
    hdr[oct_start[k] + oct_len[k] - 1] = space_end ? CH_SPACE : 8'h00;
  endtask

  task automatic put_name(int start, int len);
    int n;
    n = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) hdr[start + i] = (i < n) ? 8'($urandom_range(1, 255)) : 8'h00;
  endtask

  task automatic seal_checksum(bit use_signed);
    int unsigned us;
    int ss;
    logic [32:0] c;
    us = 0; ss = 0;
    for (int i = 0; i < HeaderBytes; i++) begin
      us += (i >= 148 && i <= 155) ? 32 : hdr[i];
      ss += (i >= 148 && i <= 155) ? 32 : int'($signed(hdr[i]));
    end
    c = (use_signed && ss >= 0) ? 33'(ss) : 33'(us);
    put_octal(FLD_CHK, c, $urandom_range(1), 1'b0);
    if ($urandom_range(1)) hdr[155] = CH_SPACE;
  endtask

  task automatic build_header(logic [7:0] t, bit lnk, bit dev, bit big);
    logic [32:0] sz;
    foreach (hdr[i]) hdr[i] = 8'h00;
    put_name(0, 100);
    put_octal(FLD_MODE, 33'($urandom), $urandom_range(2), 1'($urandom_range(1)));
    put_octal(FLD_UID, 33'($urandom), $urandom_range(2), 1'($urandom_range(1)));
    put_octal(FLD_GID, 33'($urandom), $urandom_range(2), 1'($urandom_range(1)));
    sz = big ? {1'($urandom), 32'($urandom)} : 33'($urandom_range(2000));
    if (t == "1" || t == "2") sz = 0;
    put_octal(FLD_SIZE, sz, big ? 0 : $urandom_range(3), 1'($urandom_range(1)));
    put_octal(FLD_TIME, {1'($urandom), 32'($urandom)}, 0, 1'($urandom_range(1)));
    if ($urandom_range(7) == 0)
      for (int i = 0; i < 8; i++) hdr[oct_start[FLD_MODE[2:0]] + i] = CH_SPACE;
    hdr[156] = t;
    if (lnk) put_name(157, 100);
    if (lnk && hdr[157] == 0) hdr[157] = 8'($urandom_range(1, 255));
    hdr[257] = "u"; hdr[258] = "s"; hdr[259] = "t"; hdr[260] = "a"; hdr[261] = "r";
    hdr[263] = "0"; hdr[264] = "0";
    put_name(265, 32);
    put_name(297, 32);
    if (dev) begin
      put_octal(FLD_DMAJ, 33'($urandom), $urandom_range(2), 1'($urandom_range(1)));
      put_octal(FLD_DMIN, 33'($urandom), $urandom_range(2), 1'($urandom_range(1)));
    end
    if ($urandom_range(1)) put_name(345, 155);
  endtask

  task automatic mutate(int kind);
    int k;
    k = $urandom_range(7);
    case (kind)
      MUT_FLIP: hdr[$urandom_range(511)] ^= 8'(1 << $urandom_range(7));
      MUT_MAGIC: hdr[257 + $urandom_range(4)] ^= 8'($urandom_range(1, 255));
      MUT_UNAME: for (int i = 265; i < 297; i++) hdr[i] = 8'($urandom_range(1, 255));
      MUT_GNAME: for (int i = 297; i < 329; i++) hdr[i] = 8'($urandom_range(1, 255));
      MUT_LASTD: hdr[oct_start[k] + oct_len[k] - 1] = CH_ZERO + 8'($urandom_range(7));
      MUT_BADCH: hdr[oct_start[k] + $urandom_range(oct_len[k] - 1)] = 8'($urandom);
      default: ;
    endcase
    if (kind != MUT_CHK && k != FLD_CHK) seal_checksum($urandom_range(3) == 0);
    else if (kind == MUT_CHK) hdr[150] ^= 8'h01;
  endtask

  task automatic one_header(logic [7:0] t, bit lnk, bit dev, bit big, int kind);
    build_header(t, lnk, dev, big);
    seal_checksum($urandom_range(3) == 0);
    mutate(kind);
    send_header();
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] types [14] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                               "x", "g", "K", "L", 8'h00, "A"};
    if ($urandom_range(9) == 0) return 8'($urandom);
    return types[$urandom_range(13)];
  endfunction

  task automatic test_end_marker();
    foreach (hdr[i]) hdr[i] = 8'h00;
    send_header();
    hdr[511] = 8'hff;
    send_header();
  endtask

  task automatic test_field_checks();
    for (int kind = MUT_NONE; kind < MUT_COUNT; kind++) one_header("0", 0, 0, 0, kind);
    one_header("0", 0, 0, 1, MUT_NONE);
    one_header("1", 1, 0, 0, MUT_NONE);
    one_header("5", 1, 0, 0, MUT_NONE);
    one_header("3", 0, 1, 0, MUT_NONE);
    one_header("0", 0, 1, 0, MUT_NONE);
  endtask

  task automatic test_format_modes();
    logic [7:0] types [6] = '{"x", "g", "K", "L", "7", "Z"};
    for (int m = 3; m >= 0; m--) begin
      write_format(2'(m));
      foreach (types[i]) one_header(types[i], 0, 0, 0, MUT_NONE);
    end
  endtask

  task automatic test_random_headers(int count);
    logic [7:0] t;
    for (int n = 0; n < count; n++) begin
      if (n % 12 == 11) write_format(2'($urandom_range(3)));
      t = pick_type();
      one_header(t, (t == "1" || t == "2") ? ($urandom_range(5) != 0) : ($urandom_range(9) == 0),
                 (t == "3" || t == "4") ? ($urandom_range(3) != 0) : ($urandom_range(9) == 0),
                 $urandom_range(9) == 0,
                 ($urandom_range(1) == 0) ? MUT_NONE : $urandom_range(MUT_COUNT - 1));
    end
  endtask

  task automatic check_verdict(logic [191:0] got);
    logic [191:0] want;
    bit bad;
    logic [191:0] mask;
    if (verdict_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected verdict word %h", got);
      return;
    end
    want = verdict_q.pop_front();
    bad = 0;
    for (int f = 0; f < 11; f++) begin
      mask = (192'd1 << res_w[f]) - 1;
      if (((want >> res_lo[f]) & mask) != ((got >> res_lo[f]) & mask)) begin
        bad = 1;
        if (errors < 10)
          $display("%s mismatch: expected %0h actual %0h", res_name[f],
                   (want >> res_lo[f]) & mask, (got >> res_lo[f]) & mask);
      end
    end
    if (bad) errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_verdict(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= idle_rx);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WatchLimit) begin
        $display("tb_tar_header_validator: done, errors");
        $finish;
      end
    end
  end

  initial begin
    fmt = FMT_ANY;
    clear_hdr_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_tx = 22; idle_rx = 58;
    test_end_marker();
    test_field_checks();
    test_format_modes();
    test_random_headers(20);
    idle_tx = 58; idle_rx = 22;
    test_random_headers(20);
    idle_tx = 0; idle_rx = 0;
    test_random_headers(20);
    write_format(FMT_ANY);
    drain();
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb_tar_header_validator: done, clean");
    end else begin
      $display("tb_tar_header_validator: done, errors");
    end
    $finish;
  end

endmodule
